FILE: hdl/clhm_pkg.sv
package clhm_pkg;

    localparam int DEF_TASK_SLOTS   = 16;
    localparam int DEF_TIMED_IDS    = 32;
    localparam int DEF_ALL_IDS      = 64;
    localparam int DEF_HIST_BUCKETS = 32;

    localparam logic [10:0] US_DIVISOR = 11'd1000;

    // ceil(2^36 / 1000): exact quotient for any dividend below 2^26
    localparam logic [26:0] US_RECIP       = 27'd68719477;
    localparam int          US_RECIP_SHIFT = 36;

    localparam logic [1:0] OP_ENTRY = 2'd0;
    localparam logic [1:0] OP_EXIT  = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;

    localparam logic [2:0] ST_ENTRY_STORED  = 3'd0;
    localparam logic [2:0] ST_ENTRY_IGNORED = 3'd1;
    localparam logic [2:0] ST_EXIT_MEASURED = 3'd2;
    localparam logic [2:0] ST_EXIT_NO_START = 3'd3;
    localparam logic [2:0] ST_EXIT_COUNTED  = 3'd4;
    localparam logic [2:0] ST_READ          = 3'd5;
    localparam logic [2:0] ST_BAD_ID        = 3'd6;

    // divide/square unit result
    typedef struct packed {
        logic        done;
        logic        nonzero;
        logic [5:0]  msb;
        logic [63:0] sq;
    } divsq_res_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [63:0] elapsed_ns;
        logic [4:0]  bucket;
        logic [63:0] exit_count;
        logic [63:0] total_ns;
        logic [63:0] sum_sq_us;
        logic [63:0] histo_count;
        logic [63:0] call_count;
    } result_t;

endpackage

FILE: hdl/clhm_ram.sv
module clhm_ram
    #(
        parameter int WIDTH = 64,
        parameter int DEPTH = 32,
        localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
    )
    (
        input  logic             clk,
        input  logic             we,
        input  logic [AW-1:0]    waddr,
        input  logic [WIDTH-1:0] wdata,
        input  logic             re,
        input  logic [AW-1:0]    raddr,
        output logic [WIDTH-1:0] rdata
    );

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

FILE: hdl/clhm_divsq.sv
module clhm_divsq
    import clhm_pkg::*;
    (
        input  logic        clk,
        input  logic        rst_n,
        input  logic        start,
        input  logic [63:0] dur,
        output divsq_res_t  res
    );

    typedef enum logic [2:0] {D_IDLE, D_QUO, D_REM, D_MUL0, D_MUL1, D_FIN} dstate_t;

    // position of the highest set bit, zero for a zero value
    function automatic logic [5:0] msb_of(input logic [63:0] v);
        logic [5:0] m;
        m = '0;
        for (int i = 0; i < 64; i++)
        begin
            if (v[i])
            begin
                m = 6'(i);
            end
        end
        return m;
    endfunction

    dstate_t     state_reg;
    logic [1:0]  cnt_reg;
    logic [9:0]  rem_reg;
    logic [63:0] dvd_reg;
    logic [63:0] q_reg;
    logic [15:0] qd_reg;
    logic [5:0]  msb_reg;
    logic        nz_reg;
    logic [63:0] prod_reg;
    logic [63:0] cross_reg;
    logic [63:0] sq_reg;
    logic        done_reg;

    logic [25:0] dig;
    logic [52:0] recip_p;
    logic [25:0] qd_x;
    logic [31:0] mul_b;
    logic [63:0] mul_p;

    // one 16-bit quotient digit per D_QUO/D_REM pass, high digit first
    assign dig     = {rem_reg, dvd_reg[63:48]};
    assign recip_p = dig * US_RECIP;
    assign qd_x    = qd_reg * US_DIVISOR;
    assign mul_b   = (state_reg == D_MUL0) ? q_reg[31:0] : q_reg[63:32];
    assign mul_p   = q_reg[31:0] * mul_b;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= D_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (state_reg)
                D_IDLE:
                begin
                    if (start)
                    begin
                        dvd_reg   <= dur;
                        rem_reg   <= '0;
                        q_reg     <= '0;
                        cnt_reg   <= '0;
                        nz_reg    <= |dur;
                        msb_reg   <= msb_of(dur);
                        state_reg <= D_QUO;
                    end
                end
                D_QUO:
                begin
                    qd_reg    <= recip_p[US_RECIP_SHIFT+15:US_RECIP_SHIFT];
                    state_reg <= D_REM;
                end
                D_REM:
                begin
                    rem_reg <= 10'(dig - qd_x);
                    q_reg   <= {q_reg[47:0], qd_reg};
                    dvd_reg <= {dvd_reg[47:0], 16'd0};
                    cnt_reg <= cnt_reg + 2'd1;
                    if (cnt_reg == 2'd3)
                    begin
                        state_reg <= D_MUL0;
                    end
                    else
                    begin
                        state_reg <= D_QUO;
                    end
                end
                D_MUL0:
                begin
                    prod_reg  <= mul_p;
                    state_reg <= D_MUL1;
                end
                D_MUL1:
                begin
                    cross_reg <= mul_p;
                    state_reg <= D_FIN;
                end
                D_FIN:
                begin
                    sq_reg    <= prod_reg + {cross_reg[30:0], 33'd0};
                    done_reg  <= 1'b1;
                    state_reg <= D_IDLE;
                end
                default:
                begin
                    state_reg <= D_IDLE;
                end
            endcase
        end
    end

    assign res.done    = done_reg;
    assign res.nonzero = nz_reg;
    assign res.msb     = msb_reg;
    assign res.sq      = sq_reg;

endmodule

FILE: hdl/call_latency_histogram_monitor.sv
// Channel  Fields (tdata low bit up)                                  Side
// s        tuser: operation[1:0]                                      in
//          tdata: task_slot[3:0] func_id[9:4] timestamp_ns[73:10]
//                 bucket_select[78:74], zero pad [79]
// m        tuser: status[2:0]                                         out
//          tdata: elapsed_ns, bucket, exit_count, total_ns,
//                 sum_sq_us, histo_count, call_count, zero pad
//
// One transaction at a time. Entry, read, bad-id and unmeasured exit results
// go from S_READ to S_DONE and then into the output register; a measured exit
// also passes S_DIV, waiting there for the four-digit reciprocal divide by 1000
// and the two-pass 32x32 square in clhm_divsq, and then S_HRD. After reset a
// clearing pass zeroes every memory, one entry a cycle, over as many entries as
// the deepest memory (1024 at default sizes); s_tready stays low meanwhile. A
// stalled result holds in the output register while the next transaction is
// accepted.
module call_latency_histogram_monitor
    import clhm_pkg::*;
    #(
        parameter int TASK_SLOTS   = DEF_TASK_SLOTS,
        parameter int TIMED_IDS    = DEF_TIMED_IDS,
        parameter int ALL_IDS      = DEF_ALL_IDS,
        parameter int HIST_BUCKETS = DEF_HIST_BUCKETS
    )
    (
        input  logic         clk,
        input  logic         rst_n,
        input  logic         s_tvalid,
        output logic         s_tready,
        input  logic [79:0]  s_tdata,   // task_slot, func_id, timestamp_ns, bucket_select
        input  logic [1:0]   s_tuser,   // operation
        output logic         m_tvalid,
        input  logic         m_tready,
        output logic [391:0] m_tdata,   // elapsed_ns, bucket, exit_count, total_ns,
                                        // sum_sq_us, histo_count, call_count
        output logic [2:0]   m_tuser    // status
    );

    localparam int SD   = TASK_SLOTS * TIMED_IDS;
    localparam int HD   = TIMED_IDS * HIST_BUCKETS;
    localparam int SA_W = (SD > 1) ? $clog2(SD) : 1;
    localparam int CA_W = (TIMED_IDS > 1) ? $clog2(TIMED_IDS) : 1;
    localparam int HA_W = (HD > 1) ? $clog2(HD) : 1;
    localparam int PA_W = (ALL_IDS > 1) ? $clog2(ALL_IDS) : 1;
    localparam int M1   = (SD > HD) ? SD : HD;
    localparam int M2   = (TIMED_IDS > ALL_IDS) ? TIMED_IDS : ALL_IDS;
    localparam int MAXD = (M1 > M2) ? M1 : M2;
    localparam int CW   = $clog2(MAXD);

    typedef enum logic [2:0] {S_CLR, S_IDLE, S_READ, S_DIV, S_HRD, S_DONE} state_t;

    // wrap the task slot into range by repeated subtraction (narrow value)
    function automatic logic [3:0] slot_wrap(input logic [3:0] s);
        logic [4:0] r;
        r = {1'b0, s};
        for (int i = 0; i < 16; i++)
        begin
            if (int'(r) >= TASK_SLOTS)
            begin
                r = 5'(int'(r) - TASK_SLOTS);
            end
        end
        return r[3:0];
    endfunction

    state_t      state_reg;
    logic [CW-1:0] clr_reg;
    logic [1:0]  op_reg;
    logic [5:0]  id_reg;
    logic [63:0] ts_reg;
    logic [4:0]  sel_reg;
    logic [SA_W-1:0] sa_reg;
    logic [HA_W-1:0] ha_reg;
    logic [63:0] dur_reg;
    logic [4:0]  bkt_reg;
    logic        div_start_reg;
    result_t     pend_reg;
    result_t     out_reg;
    logic        out_valid_reg;

    logic [3:0]  in_slot;
    logic [5:0]  in_id;
    logic [4:0]  in_sel;
    logic        acc;

    logic            s_we, c_we, h_we, p_we, rd_en, h_re;
    logic [SA_W-1:0] s_wa;
    logic [CA_W-1:0] c_wa, c_ra;
    logic [HA_W-1:0] h_wa, h_ra;
    logic [PA_W-1:0] p_wa, p_ra;
    logic [63:0]     s_wd, h_wd, p_wd;
    logic [191:0]    c_wd;
    logic [63:0]     s_rd, h_rd, p_rd;
    logic [191:0]    c_rd;

    divsq_res_t dres;
    logic       id_ok, timed;
    logic [63:0] dur_now;
    int         bclamp;

    assign in_slot = s_tdata[3:0];
    assign in_id   = s_tdata[9:4];
    assign in_sel  = s_tdata[78:74];
    assign s_tready = (state_reg == S_IDLE);
    assign acc     = s_tvalid && s_tready;

    assign id_ok   = (op_reg == OP_ENTRY || op_reg == OP_EXIT || op_reg == OP_READ)
                     && (int'(id_reg) < ALL_IDS);
    assign timed   = int'(id_reg) < TIMED_IDS;
    assign dur_now = ts_reg - s_rd;
    assign bclamp  = (int'(dres.msb) >= HIST_BUCKETS) ? HIST_BUCKETS - 1 : int'(dres.msb);

    // memory port control
    always_comb
    begin
        s_we = 1'b0;  s_wa = sa_reg;  s_wd = '0;
        c_we = 1'b0;  c_wa = CA_W'(id_reg);  c_wd = '0;
        h_we = 1'b0;  h_wa = ha_reg;  h_wd = '0;
        p_we = 1'b0;  p_wa = PA_W'(id_reg);  p_wd = '0;
        rd_en = acc;
        h_re  = acc;
        c_ra  = CA_W'(in_id);
        p_ra  = PA_W'(in_id);
        h_ra  = HA_W'(int'(in_id) * HIST_BUCKETS + int'(in_sel));
        unique case (state_reg)
            S_CLR:
            begin
                s_we = 1'b1;  s_wa = SA_W'(clr_reg);
                c_we = 1'b1;  c_wa = CA_W'(clr_reg);
                h_we = 1'b1;  h_wa = HA_W'(clr_reg);
                p_we = 1'b1;  p_wa = PA_W'(clr_reg);
            end
            S_READ:
            begin
                if (id_ok && op_reg == OP_ENTRY && timed)
                begin
                    s_we = 1'b1;
                    s_wd = ts_reg;
                end
                else if (id_ok && op_reg == OP_EXIT && timed && s_rd != 64'd0)
                begin
                    s_we = 1'b1;   // drop the held start
                end
                else if (id_ok && op_reg == OP_EXIT && !timed)
                begin
                    p_we = 1'b1;
                    p_wd = p_rd + 64'd1;
                end
            end
            S_DIV:
            begin
                h_re = dres.done;
                h_ra = HA_W'(int'(id_reg) * HIST_BUCKETS + bclamp);
            end
            S_HRD:
            begin
                c_we = 1'b1;
                c_wd = {c_rd[191:128] + pend_reg.sum_sq_us,
                        c_rd[127:64] + dur_reg,
                        c_rd[63:0] + 64'd1};
                h_we = dres.nonzero;
                h_wd = h_rd + 64'd1;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLR;
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
            div_start_reg <= 1'b0;
        end
        else
        begin
            div_start_reg <= 1'b0;
            if (out_valid_reg && m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_CLR:
                begin
                    clr_reg <= clr_reg + CW'(1);
                    if (int'(clr_reg) == MAXD - 1)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE:
                begin
                    if (acc)
                    begin
                        op_reg    <= s_tuser;
                        id_reg    <= in_id;
                        ts_reg    <= s_tdata[73:10];
                        sel_reg   <= in_sel;
                        sa_reg    <= SA_W'(int'(slot_wrap(in_slot)) * TIMED_IDS + int'(in_id));
                        ha_reg    <= HA_W'(int'(in_id) * HIST_BUCKETS + int'(in_sel));
                        state_reg <= S_READ;
                    end
                end
                S_READ:
                begin
                    pend_reg  <= '0;
                    state_reg <= S_DONE;
                    if (!id_ok)
                    begin
                        pend_reg.status <= ST_BAD_ID;
                    end
                    else
                    begin
                        unique case (op_reg)
                            OP_ENTRY:
                            begin
                                pend_reg.status <= timed ? ST_ENTRY_STORED
                                                         : ST_ENTRY_IGNORED;
                            end
                            OP_EXIT:
                            begin
                                if (!timed)
                                begin
                                    pend_reg.status <= ST_EXIT_COUNTED;
                                end
                                else if (s_rd == 64'd0)
                                begin
                                    pend_reg.status <= ST_EXIT_NO_START;
                                end
                                else
                                begin
                                    dur_reg       <= dur_now;
                                    div_start_reg <= 1'b1;
                                    state_reg     <= S_DIV;
                                end
                            end
                            default:
                            begin
                                pend_reg.status <= ST_READ;
                                if (timed)
                                begin
                                    pend_reg.exit_count <= c_rd[63:0];
                                    pend_reg.total_ns   <= c_rd[127:64];
                                    pend_reg.sum_sq_us  <= c_rd[191:128];
                                    if (int'(sel_reg) < HIST_BUCKETS)
                                    begin
                                        pend_reg.histo_count <= h_rd;
                                    end
                                end
                                else
                                begin
                                    pend_reg.call_count <= p_rd;
                                end
                            end
                        endcase
                    end
                end
                S_DIV:
                begin
                    if (dres.done)
                    begin
                        // point the histogram write at the bucket just read
                        ha_reg             <= HA_W'(int'(id_reg) * HIST_BUCKETS + bclamp);
                        bkt_reg            <= dres.nonzero ? 5'(bclamp) : 5'd0;
                        pend_reg.sum_sq_us <= dres.sq;
                        state_reg          <= S_HRD;
                    end
                end
                S_HRD:
                begin
                    pend_reg            <= '0;
                    pend_reg.status     <= ST_EXIT_MEASURED;
                    pend_reg.elapsed_ns <= dur_reg;
                    pend_reg.bucket     <= bkt_reg;
                    state_reg           <= S_DONE;
                end
                S_DONE:
                begin
                    // hand over once the output register is free
                    if (!out_valid_reg || m_tready)
                    begin
                        out_reg       <= pend_reg;
                        out_valid_reg <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    clhm_ram #(.WIDTH(64), .DEPTH(SD)) u_start_ram
    (
        .clk(clk), .we(s_we), .waddr(s_wa), .wdata(s_wd),
        .re(rd_en), .raddr(SA_W'(int'(slot_wrap(in_slot)) * TIMED_IDS + int'(in_id))),
        .rdata(s_rd)
    );

    clhm_ram #(.WIDTH(192), .DEPTH(TIMED_IDS)) u_cnt_ram
    (
        .clk(clk), .we(c_we), .waddr(c_wa), .wdata(c_wd),
        .re(rd_en), .raddr(c_ra), .rdata(c_rd)
    );

    clhm_ram #(.WIDTH(64), .DEPTH(HD)) u_hist_ram
    (
        .clk(clk), .we(h_we), .waddr(h_wa), .wdata(h_wd),
        .re(h_re), .raddr(h_ra), .rdata(h_rd)
    );

    clhm_ram #(.WIDTH(64), .DEPTH(ALL_IDS)) u_plain_ram
    (
        .clk(clk), .we(p_we), .waddr(p_wa), .wdata(p_wd),
        .re(rd_en), .raddr(p_ra), .rdata(p_rd)
    );

    clhm_divsq u_divsq
    (
        .clk(clk), .rst_n(rst_n), .start(div_start_reg), .dur(dur_reg), .res(dres)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_reg.status;
    assign m_tdata  = {3'd0, out_reg.call_count, out_reg.histo_count, out_reg.sum_sq_us,
                       out_reg.total_ns, out_reg.exit_count, out_reg.bucket,
                       out_reg.elapsed_ns};

endmodule

FILE: hdl/clhm_chk.sv
module clhm_chk
    import clhm_pkg::*;
    (
        input logic         clk,
        input logic         rst_n,
        input logic         s_tvalid,
        input logic         s_tready,
        input logic         m_tvalid,
        input logic         m_tready,
        input logic [391:0] m_tdata,
        input logic [2:0]   m_tuser
    );

    // stalled result stays offered
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped while stalled");

    a_status: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tuser <= ST_BAD_ID)
        else $error("undefined status");

    a_one: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second transaction taken while busy");

    a_dur: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser != ST_EXIT_MEASURED |-> m_tdata[68:0] == 69'd0)
        else $error("duration or bucket on non-measured result");

    a_bad: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser == ST_BAD_ID |-> m_tdata == 392'd0)
        else $error("out of range result carries data");

endmodule

bind call_latency_histogram_monitor clhm_chk u_clhm_chk
(
    .clk(clk), .rst_n(rst_n), .s_tvalid(s_tvalid), .s_tready(s_tready),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
);

FILE: bench/tb_call_latency_histogram_monitor.sv
`timescale 1ns / 1ps

module tb_call_latency_histogram_monitor;
    import clhm_pkg::*;

    localparam int SLOTS   = DEF_TASK_SLOTS;
    localparam int TIMED   = DEF_TIMED_IDS;
    localparam int IDS     = DEF_ALL_IDS;
    localparam int BUCKETS = DEF_HIST_BUCKETS;

    // One trace event as the block sees it.
    typedef struct packed {
        logic [1:0]  operation;
        logic [3:0]  task_slot;
        logic [5:0]  func_id;
        logic [63:0] timestamp_ns;
        logic [4:0]  bucket_select;
    } trace_event_t;

    logic         clk;
    logic         rst_n;
    logic         s_tvalid;
    logic         s_tready;
    logic [79:0]  s_tdata;   // task_slot, func_id, timestamp_ns, bucket_select, pad
    logic [1:0]   s_tuser;   // operation
    logic         m_tvalid;
    logic         m_tready;
    logic [391:0] m_tdata;   // elapsed_ns, bucket, exit_count, total_ns,
                             // sum_sq_us, histo_count, call_count, pad
    logic [2:0]   m_tuser;   // status

    call_latency_histogram_monitor u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // Shadow copy of the block's counters and start times.
    logic [63:0] start_ns    [SLOTS*TIMED];
    logic [63:0] exits_seen  [TIMED];
    logic [63:0] total_dur   [TIMED];
    logic [63:0] sq_us_sum   [TIMED];
    logic [63:0] histo       [TIMED*BUCKETS];
    logic [63:0] plain_calls [IDS];

    trace_event_t pending_events[$];
    result_t      expected_results[$];

    int  fail_count = 0;
    bit  stim_done = 0;
    bit  hold_off = 0;
    int  rx_phase = 0;

    always
    begin
        clk = 1'b1;
        #10;
        clk = 1'b0;
        #10;
    end

    // Compute the result an event produces and advance the shadow state.
    function automatic result_t predict_event(trace_event_t ev);
        result_t     r;
        int          slot;
        int          id;
        int          idx;
        logic [63:0] dur;
        logic [63:0] us;
        int          b;
        r    = '0;
        slot = ev.task_slot % SLOTS;
        id   = ev.func_id;
        idx  = slot * TIMED + id;
        if (ev.operation != OP_ENTRY && ev.operation != OP_EXIT && ev.operation != OP_READ
            || id >= IDS)
        begin
            r.status = ST_BAD_ID;
        end
        else if (ev.operation == OP_ENTRY)
        begin
            if (id < TIMED)
            begin
                start_ns[idx] = ev.timestamp_ns;
                r.status = ST_ENTRY_STORED;
            end
            else
                r.status = ST_ENTRY_IGNORED;
        end
        else if (ev.operation == OP_EXIT)
        begin
            if (id >= TIMED)
            begin
                plain_calls[id] += 64'd1;
                r.status = ST_EXIT_COUNTED;
            end
            else if (start_ns[idx] == 64'd0)
                r.status = ST_EXIT_NO_START;
            else
            begin
                dur = ev.timestamp_ns - start_ns[idx];
                us  = dur / 64'd1000;
                start_ns[idx] = 64'd0;
                exits_seen[id] += 64'd1;
                total_dur[id]  += dur;
                sq_us_sum[id]  += us * us;
                r.status     = ST_EXIT_MEASURED;
                r.elapsed_ns = dur;
                if (dur != 64'd0)
                begin
                    b = 0;
                    for (int i = 0; i < 64; i++)
                        if (dur[i])
                            b = i;
                    if (b >= BUCKETS)
                        b = BUCKETS - 1;
                    histo[id*BUCKETS + b] += 64'd1;
                    r.bucket = b[4:0];
                end
            end
        end
        else
        begin
            r.status = ST_READ;
            if (id < TIMED)
            begin
                r.exit_count = exits_seen[id];
                r.total_ns   = total_dur[id];
                r.sum_sq_us  = sq_us_sum[id];
                if (ev.bucket_select < BUCKETS)
                    r.histo_count = histo[id*BUCKETS + ev.bucket_select];
            end
            else
                r.call_count = plain_calls[id];
        end
        return r;
    endfunction

    function automatic trace_event_t make_event(logic [1:0] op, int slot, int id,
                                                logic [63:0] ts, int sel);
        trace_event_t ev;
        ev.operation     = op;
        ev.task_slot     = slot[3:0];
        ev.func_id       = id[5:0];
        ev.timestamp_ns  = ts;
        ev.bucket_select = sel[4:0];
        return ev;
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // Durations spread over every power of two, with some zero and huge ones.
    function automatic logic [63:0] rand_duration();
        int sh;
        sh = $urandom_range(0, 63);
        case ($urandom_range(0, 9))
            0:       return 64'd0;
            1:       return rand64();
            default: return rand64() >> sh;
        endcase
    endfunction

    // Remember whether the current item was taken at the last rising edge.
    logic s_tready_q;

    // Driver: bursts of random length with random gaps, changes on the falling edge.
    int burst_left = 0;
    int gap_left = 0;
    always @(negedge clk)
    begin
        if (rst_n && !(s_tvalid && !s_tready_q))
        begin
            if (s_tvalid && s_tready_q)
                void'(pending_events.pop_front());
            if (gap_left > 0)
            begin
                gap_left <= gap_left - 1;
                s_tvalid <= 1'b0;
            end
            else if (pending_events.size() > 0)
            begin
                s_tvalid <= 1'b1;
                {s_tdata, s_tuser} <= {1'b0, pending_events[0].bucket_select,
                                       pending_events[0].timestamp_ns,
                                       pending_events[0].func_id,
                                       pending_events[0].task_slot,
                                       pending_events[0].operation};
                if (burst_left > 0)
                    burst_left <= burst_left - 1;
                else
                begin
                    burst_left <= $urandom_range(0, 20);
                    gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                end
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s_tready_q <= 1'b0;
        else
        begin
            s_tready_q <= s_tvalid && s_tready;
            if (s_tvalid && s_tready)
                expected_results.push_back(predict_event(pending_events[0]));
        end
    end

    // Receiver stall pattern: phases of always-ready, random stalls, long hold-off.
    always @(negedge clk)
    begin
        if (!rst_n || hold_off)
            m_tready <= 1'b0;
        else
            case (rx_phase)
                0:       m_tready <= 1'b1;
                1:       m_tready <= ($urandom_range(0, 3) != 0);
                default: m_tready <= ($urandom_range(0, 1) != 0);
            endcase
    end

    // Monitor: compare every accepted result against the oldest prediction.
    always @(posedge clk)
    begin
        result_t got;
        result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got.status      = m_tuser;
            got.elapsed_ns  = m_tdata[63:0];
            got.bucket      = m_tdata[68:64];
            got.exit_count  = m_tdata[132:69];
            got.total_ns    = m_tdata[196:133];
            got.sum_sq_us   = m_tdata[260:197];
            got.histo_count = m_tdata[324:261];
            got.call_count  = m_tdata[388:325];
            if (expected_results.size() == 0)
            begin
                $error("unexpected result transaction, status %0d", m_tuser);
                fail_count++;
            end
            else
            begin
                want = expected_results.pop_front();
                if (got.status != want.status)
                begin
                    $error("status: expected %0d actual %0d", want.status, got.status);
                    fail_count++;
                end
                if (got.elapsed_ns != want.elapsed_ns)
                begin
                    $error("elapsed_ns: expected %0d actual %0d",
                           want.elapsed_ns, got.elapsed_ns);
                    fail_count++;
                end
                if (got.bucket != want.bucket)
                begin
                    $error("bucket: expected %0d actual %0d", want.bucket, got.bucket);
                    fail_count++;
                end
                if (got.exit_count != want.exit_count)
                begin
                    $error("exit_count: expected %0d actual %0d",
                           want.exit_count, got.exit_count);
                    fail_count++;
                end
                if (got.total_ns != want.total_ns)
                begin
                    $error("total_ns: expected %0d actual %0d", want.total_ns, got.total_ns);
                    fail_count++;
                end
                if (got.sum_sq_us != want.sum_sq_us)
                begin
                    $error("sum_sq_us: expected %0d actual %0d",
                           want.sum_sq_us, got.sum_sq_us);
                    fail_count++;
                end
                if (got.histo_count != want.histo_count)
                begin
                    $error("histo_count: expected %0d actual %0d",
                           want.histo_count, got.histo_count);
                    fail_count++;
                end
                if (got.call_count != want.call_count)
                begin
                    $error("call_count: expected %0d actual %0d",
                           want.call_count, got.call_count);
                    fail_count++;
                end
            end
        end
    end

    // Stimulus and end of run.
    initial
    begin
        int          slot;
        int          id;
        logic [63:0] t0;
        rst_n    = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = '0;
        m_tready = 1'b0;
        foreach (start_ns[i])    start_ns[i] = '0;
        foreach (exits_seen[i])  exits_seen[i] = '0;
        foreach (total_dur[i])   total_dur[i] = '0;
        foreach (sq_us_sum[i])   sq_us_sum[i] = '0;
        foreach (histo[i])       histo[i] = '0;
        foreach (plain_calls[i]) plain_calls[i] = '0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: zero-time entry, untimed entry, repeat entry, zero and huge durations,
        // exit with no start, bad op, top bucket select, reads of both kinds.
        pending_events.push_back(make_event(OP_ENTRY, 0, 0, 64'd0, 0));
        pending_events.push_back(make_event(OP_EXIT, 0, 0, 64'd5, 0));
        pending_events.push_back(make_event(OP_ENTRY, 15, 31, 64'd100, 31));
        pending_events.push_back(make_event(OP_ENTRY, 15, 31, 64'd200, 31));
        pending_events.push_back(make_event(OP_EXIT, 15, 31, 64'd200, 31));
        pending_events.push_back(make_event(OP_ENTRY, 3, 5, '1, 0));
        pending_events.push_back(make_event(OP_EXIT, 3, 5, 64'hFFFF_FFFF_FFFF_FFFE, 0));
        pending_events.push_back(make_event(OP_ENTRY, 4, 6, 64'd1, 0));
        pending_events.push_back(make_event(OP_EXIT, 4, 6, '1, 0));
        pending_events.push_back(make_event(OP_ENTRY, 7, 9, 64'd1000, 0));
        pending_events.push_back(make_event(OP_EXIT, 7, 9, 64'd3_001_000, 0));
        pending_events.push_back(make_event(OP_ENTRY, 2, 40, 64'd77, 0));
        pending_events.push_back(make_event(OP_EXIT, 2, 63, 64'd77, 0));
        pending_events.push_back(make_event(OP_EXIT, 2, 63, 64'd78, 0));
        pending_events.push_back(make_event(2'd3, 1, 1, 64'd1, 1));
        pending_events.push_back(make_event(OP_READ, 0, 63, 64'd0, 31));
        pending_events.push_back(make_event(OP_READ, 0, 31, 64'd0, 7));
        pending_events.push_back(make_event(OP_READ, 0, 5, 64'd0, 31));
        pending_events.push_back(make_event(OP_READ, 0, 6, 64'd0, 31));
        pending_events.push_back(make_event(OP_READ, 0, 9, 64'd0, 21));
        pending_events.push_back(make_event(OP_READ, 0, 0, 64'd0, 0));

        // Random: mostly entry/exit pairs on the same slot and id, plus noise.
        while (pending_events.size() < 1420)
        begin
            slot = $urandom_range(0, 15);
            id   = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 63) : $urandom_range(0, 31);
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4:
                begin
                    t0 = rand64();
                    pending_events.push_back(make_event(OP_ENTRY, slot, id, t0, $urandom));
                    pending_events.push_back(make_event(OP_EXIT, slot, id,
                                                        t0 + rand_duration(), $urandom));
                end
                5:       pending_events.push_back(make_event(OP_EXIT, slot, id, rand64(),
                                                             $urandom));
                6, 7:    pending_events.push_back(make_event(OP_READ, slot, id, rand64(),
                                                             $urandom));
                8:       pending_events.push_back(make_event(OP_ENTRY, slot, id, rand64(),
                                                             $urandom));
                default: pending_events.push_back(make_event(2'($urandom), slot, id,
                                                             rand64(), $urandom));
            endcase
            if (pending_events.size() == 400)
                pending_events.push_back(make_event(OP_READ, 0, 0, '1, 31));
        end

        // Cycle the receiver through its stall patterns, with long hold-offs mid-run.
        fork
            begin
                while (pending_events.size() > 0)
                begin
                    rx_phase = $urandom_range(0, 2);
                    repeat ($urandom_range(50, 400)) @(posedge clk);
                    if (pending_events.size() > 700 && pending_events.size() < 900)
                    begin
                        hold_off = 1;
                        repeat (300) @(posedge clk);
                        hold_off = 0;
                    end
                end
            end
        join_none
        wait (pending_events.size() == 0);
        rx_phase = 0;
        wait (expected_results.size() == 0);
        repeat (200) @(posedge clk);
        if (fail_count == 0 && expected_results.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    // Watchdog: about 1420 items, plus stalls, gaps, hold-offs and the clearing pass,
    // stay far below this bound.
    initial
    begin
        #20_000_000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule
